// ===== sv/rcsa_pkg.sv =====
// ----------------------------------------------------------------------------
// rcsa_pkg: shared definitions of the range-constrained slot allocator
// Sizes, status and request codes, register indexes and the structs that
// travel between the allocator's modules.
// ----------------------------------------------------------------------------
package rcsa_pkg;

   // Slot store geometry.
   localparam int MAX_SLOTS  = 256;
   localparam int SLOT_BYTES = 16;
   localparam int IDX_W      = $clog2(MAX_SLOTS);
   localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
   localparam int NUM_ITEMS_RESET = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;

   // Cache line extraction: address bits from 5 upward, at most 31 of them.
   localparam int LINE_LSB = 5;
   localparam int LINE_W   = 31;
   localparam int LINE_MSB = LINE_LSB + LINE_W - 1;

   // Request codes.
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // Result status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_NO_FIT   = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   // Register indexes.
   localparam logic CSR_CHUNK_BASE = 1'b0;
   localparam logic CSR_NUM_ITEMS  = 1'b1;

   // Write into the free stack.
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [IDX_W-1:0] data;
   } stk_wr_type;

   // Read beat returned by the free stack, in the cycle after the request.
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] addr;
      logic [IDX_W-1:0] data;
   } stk_rd_type;

   // Parameters of the allocation being scanned.
   typedef struct packed {
      logic [63:0]       range_low;
      logic [63:0]       range_high;
      logic [LINE_W-1:0] from_line;
      logic [LINE_W-1:0] to_line;
      logic [LINE_W-1:0] mask;
      logic              check;
   } query_type;

   // Verdict on one scanned entry.
   typedef struct packed {
      logic             valid;
      logic             hit;
      logic [IDX_W-1:0] pos;
      logic [IDX_W-1:0] slot;
   } match_type;

endpackage

// ===== sv/rcsa_ram.sv =====
// ----------------------------------------------------------------------------
// rcsa_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rcsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Storage array with registered read data.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/rcsa_stack.sv =====
// ----------------------------------------------------------------------------
// rcsa_stack: free slot stack storage
// A RAM plus one written bit per entry; an entry never written since the last
// reset or refill reads as its own position.
// ----------------------------------------------------------------------------
module rcsa_stack (
   input  logic                clock,
   input  logic                reset,
   input  logic                refill,
   input  rcsa_pkg::stk_wr_type wr,
   input  logic                rd_en,
   input  logic [rcsa_pkg::IDX_W-1:0] rd_addr,
   output rcsa_pkg::stk_rd_type rd
);
   import rcsa_pkg::*;

   logic [MAX_SLOTS-1:0] written_ff;
   logic [MAX_SLOTS-1:0] written_in;
   logic                 rd_valid_ff;
   logic                 rd_written_ff;
   logic [IDX_W-1:0]     rd_addr_ff;
   logic [IDX_W-1:0]     ram_q;

   rcsa_ram #(
      .WIDTH(IDX_W),
      .DEPTH(MAX_SLOTS)
   ) u_ram (
      .clock(clock),
      .we   (wr.en),
      .waddr(wr.addr),
      .wdata(wr.data),
      .re   (rd_en),
      .raddr(rd_addr),
      .rdata(ram_q)
   );

   // Written bits: cleared at reset and refill, set by each write.
   always_comb begin
      written_in = written_ff;
      if (wr.en) begin
         written_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || refill) begin
         written_ff  <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         written_ff  <= written_in;
         rd_valid_ff <= rd_en;
      end
   end

   // Side information that travels with the read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_written_ff <= written_ff[rd_addr];
         rd_addr_ff    <= rd_addr;
      end
   end

   assign rd.valid = rd_valid_ff;
   assign rd.addr  = rd_addr_ff;
   assign rd.data  = rd_written_ff ? ram_q : rd_addr_ff;

endmodule

// ===== sv/rcsa_match.sv =====
// ----------------------------------------------------------------------------
// rcsa_match: slot fitness test
// Two stages: the slot address is formed and registered, then checked against
// the range and the two cache lines to avoid.
// ----------------------------------------------------------------------------
module rcsa_match (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 flush,
   input  rcsa_pkg::stk_rd_type  beat,
   input  logic [63:0]          chunk_base,
   input  rcsa_pkg::query_type   query,
   output rcsa_pkg::match_type   result
);
   import rcsa_pkg::*;

   logic              a_valid_ff;
   logic [63:0]       a_addr_ff;
   logic [IDX_W-1:0]  a_pos_ff;
   logic [IDX_W-1:0]  a_slot_ff;
   logic [35:0]       end_addr;
   logic [LINE_W-1:0] start_line;
   logic [LINE_W-1:0] end_line;
   logic              in_range;
   logic              conflict;

   // Stage A: start address of the slot.
   always_ff @(posedge clock) begin
      if (reset || flush) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= beat.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (beat.valid) begin
         a_addr_ff <= chunk_base + 64'(beat.data) * 64'(SLOT_BYTES);
         a_pos_ff  <= beat.addr;
         a_slot_ff <= beat.data;
      end
   end

   // Stage B: range check and cache line test on the last and first byte.
   always_comb begin
      end_addr   = a_addr_ff[35:0] + 36'(SLOT_BYTES - 1);
      start_line = a_addr_ff[LINE_MSB:LINE_LSB] & query.mask;
      end_line   = end_addr[LINE_MSB:LINE_LSB] & query.mask;
      in_range   = (a_addr_ff >= query.range_low) && (a_addr_ff <= query.range_high);
      conflict   = (query.from_line == start_line) || (query.from_line == end_line) ||
                   (query.to_line == start_line) || (query.to_line == end_line);
   end

   assign result.valid = a_valid_ff;
   assign result.hit   = in_range && !(query.check && conflict);
   assign result.pos   = a_pos_ff;
   assign result.slot  = a_slot_ff;

endmodule

// ===== sv/range_constrained_slot_allocator_top.sv =====
// ----------------------------------------------------------------------------
// range_constrained_slot_allocator_top: free slot allocator with range and
// cache line constraints
// Keeps a stack of free slot indices and serves allocate and return requests.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the req_ channel, one beat each, and every request gives
// exactly one beat on the rsp_ channel (status and slot index). Both channels
// use valid and stall. The block works on one request at a time: req_stall is
// high from the accepted beat until its result is loaded into the output
// register, so the next request can be taken while that result waits.
// A return, or an allocate on an empty stack, goes straight to the done state.
// An allocate reads the free stack from the top down, one entry per cycle through
// the stack RAM's read port, and evaluates each entry in a two-stage address and
// compare pipeline; the scan ends at the first hit or, with no fit, once the
// bottom entry has been evaluated.
// When rsp_stall holds a result, the next finished result waits in the block
// until the output register is free.
// Reset clears the chunk base, sets the slot count to 256 and makes the stack
// hold every slot in order at once; writing csr num_items does the same refill.
// The user writes configuration only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module range_constrained_slot_allocator_top (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [63:0] req_range_low,
   input  logic [63:0] req_range_high,
   input  logic [63:0] req_from_addr,
   input  logic [63:0] req_to_addr,
   input  logic [4:0]  req_line_count_log2,
   input  logic        req_check_conflict,
   input  logic [7:0]  req_free_index,
   // Result channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_slot_index,
   // Configuration write port.
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);
   import rcsa_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   state_type         state_ff;
   logic [63:0]       chunk_base_ff;
   logic [CNT_W-1:0]  num_items_ff;
   logic [CNT_W-1:0]  num_items_in;
   logic [CNT_W-1:0]  free_count_ff;
   query_type         query_ff;
   query_type         query_in;
   logic [LINE_W-1:0] mask_in;
   logic [IDX_W-1:0]  rd_pos_ff;
   logic [CNT_W-1:0]  rd_left_ff;
   logic              first_ff;
   logic [IDX_W-1:0]  top_ff;
   logic [1:0]        res_status_ff;
   logic [IDX_W-1:0]  res_slot_ff;
   logic              wr_pending_ff;
   logic [IDX_W-1:0]  wr_addr_ff;
   logic [IDX_W-1:0]  wr_data_ff;
   logic              cnt_inc_ff;
   logic              cnt_dec_ff;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [IDX_W-1:0]  rsp_slot_ff;
   logic              out_free;
   logic              rd_en;
   logic              refill;
   logic              scanning;
   logic              stack_full;
   stk_wr_type        stk_wr;
   stk_rd_type        stk_rd;
   match_type         match;

   // Handshake and control decode.
   assign req_stall  = (state_ff != S_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign scanning   = (state_ff == S_SCAN);
   assign rd_en      = scanning && (rd_left_ff != '0);
   assign refill     = csr_we && (csr_index == CSR_NUM_ITEMS);
   assign stack_full = (free_count_ff >= num_items_ff);

   // Saturate the written slot count.
   always_comb begin
      num_items_in = csr_wdata[CNT_W-1:0];
      if (csr_wdata[CNT_W-1:0] > CNT_W'(MAX_SLOTS)) begin
         num_items_in = CNT_W'(MAX_SLOTS);
      end
   end

   // Query parameters taken at acceptance; cache line mask and avoided lines.
   always_comb begin
      mask_in             = ~({LINE_W{1'b1}} << req_line_count_log2);
      query_in.range_low  = req_range_low;
      query_in.range_high = req_range_high;
      query_in.mask       = mask_in;
      query_in.from_line  = req_from_addr[LINE_MSB:LINE_LSB] & mask_in;
      query_in.to_line    = req_to_addr[LINE_MSB:LINE_LSB] & mask_in;
      query_in.check      = req_check_conflict;
   end

   // Stack write at completion: a push, or the top moved into the taken entry.
   always_comb begin
      stk_wr.en   = (state_ff == S_DONE) && out_free && wr_pending_ff;
      stk_wr.addr = wr_addr_ff;
      stk_wr.data = wr_data_ff;
   end

   rcsa_stack u_stack (
      .clock  (clock),
      .reset  (reset),
      .refill (refill),
      .wr     (stk_wr),
      .rd_en  (rd_en),
      .rd_addr(rd_pos_ff),
      .rd     (stk_rd)
   );

   rcsa_match u_match (
      .clock     (clock),
      .reset     (reset),
      .flush     (!scanning),
      .beat      (stk_rd),
      .chunk_base(chunk_base_ff),
      .query     (query_ff),
      .result    (match)
   );

   // Sequencer, counters and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         chunk_base_ff <= '0;
         num_items_ff  <= CNT_W'(NUM_ITEMS_RESET);
         free_count_ff <= CNT_W'(NUM_ITEMS_RESET);
         rsp_valid_ff  <= 1'b0;
         wr_pending_ff <= 1'b0;
         cnt_inc_ff    <= 1'b0;
         cnt_dec_ff    <= 1'b0;
         rd_left_ff    <= '0;
         first_ff      <= 1'b0;
      end else begin
         // A taken result beat empties the output register unless a new one loads.
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         // Configuration writes.
         if (csr_we && (csr_index == CSR_CHUNK_BASE)) begin
            chunk_base_ff <= csr_wdata;
         end
         if (refill) begin
            num_items_ff  <= num_items_in;
            free_count_ff <= num_items_in;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  query_ff      <= query_in;
                  res_slot_ff   <= '0;
                  cnt_dec_ff    <= 1'b0;
                  wr_addr_ff    <= free_count_ff[IDX_W-1:0];
                  wr_data_ff    <= req_free_index;
                  if (req_type == REQ_FREE) begin
                     res_status_ff <= stack_full ? ST_OVERFLOW : ST_OK;
                     wr_pending_ff <= !stack_full;
                     cnt_inc_ff    <= !stack_full;
                     state_ff      <= S_DONE;
                  end else begin
                     wr_pending_ff <= 1'b0;
                     cnt_inc_ff    <= 1'b0;
                     if (free_count_ff == '0) begin
                        res_status_ff <= ST_EMPTY;
                        state_ff      <= S_DONE;
                     end else begin
                        rd_pos_ff  <= IDX_W'(free_count_ff - CNT_W'(1));
                        rd_left_ff <= free_count_ff;
                        first_ff   <= 1'b1;
                        state_ff   <= S_SCAN;
                     end
                  end
               end
            end

            S_SCAN: begin
               if (rd_en) begin
                  rd_pos_ff  <= rd_pos_ff - IDX_W'(1);
                  rd_left_ff <= rd_left_ff - CNT_W'(1);
               end
               // The first entry read is the top of the stack.
               if (stk_rd.valid && first_ff) begin
                  top_ff   <= stk_rd.data;
                  first_ff <= 1'b0;
               end
               if (match.valid && match.hit) begin
                  res_status_ff <= ST_OK;
                  res_slot_ff   <= match.slot;
                  wr_pending_ff <= 1'b1;
                  wr_addr_ff    <= match.pos;
                  wr_data_ff    <= top_ff;
                  cnt_dec_ff    <= 1'b1;
                  state_ff      <= S_DONE;
               end else if (match.valid && (match.pos == '0)) begin
                  res_status_ff <= ST_NO_FIT;
                  state_ff      <= S_DONE;
               end
            end

            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_slot_ff   <= res_slot_ff;
                  if (cnt_inc_ff) begin
                     free_count_ff <= free_count_ff + CNT_W'(1);
                  end else if (cnt_dec_ff) begin
                     free_count_ff <= free_count_ff - CNT_W'(1);
                  end
                  state_ff <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;

endmodule
